FILE: design/tmsa_pkg.sv
// shared types, constants and state encoding for the trimmed mean / deviation accumulator
package tmsa_pkg;

    localparam int MAX_SAMPLES = 16;

    localparam int SAMPLE_W = 16;
    localparam int COUNT_W  = 7;
    localparam int SUM_W    = 23;
    localparam int SQSUM_W  = 37;
    localparam int SQ_W     = 32;
    localparam int PROD_W   = 43;
    localparam int ASUM_W   = 22;
    localparam int NN_W     = 12;
    localparam int MAG_W    = 23;
    localparam int NUM_W    = 25;
    localparam int SHREG_W  = 60;
    localparam int ROOT_W   = 30;
    localparam int DEV_W    = 24;
    localparam int UNIT_W   = 34;
    localparam int STEP_W   = 6;
    localparam int FRAC_W   = 16;

    localparam int DEV_STEPS  = SHREG_W;
    localparam int SQRT_STEPS = SHREG_W / 2;
    localparam int AVG_STEPS  = MAG_W;

    localparam logic signed [SAMPLE_W-1:0] MIN_RESET = 16'sd30000;
    localparam logic signed [SAMPLE_W-1:0] MAX_RESET = -16'sd30000;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQUARE,
        S_ACCUM,
        S_TRIM,
        S_TRIM_MIN,
        S_MUL_A,
        S_MUL_B,
        S_DIFF,
        S_DEV_DIV,
        S_SQRT,
        S_AVG_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic capture;
        logic square;
        logic add;
        logic clear;
    } t_acc_ctl;

    typedef struct packed {
        logic        [COUNT_W-1:0]  count;
        logic signed [SUM_W-1:0]    sum;
        logic        [SQSUM_W-1:0]  sqsum;
        logic signed [SAMPLE_W-1:0] min_val;
        logic signed [SAMPLE_W-1:0] max_val;
    } t_acc_vals;

    typedef struct packed {
        logic              ge;
        logic [UNIT_W-1:0] res;
    } t_unit_out;

    typedef struct packed {
        logic        [DEV_W-1:0]    deviation_q8;
        logic signed [SAMPLE_W-1:0] largest;
        logic signed [SAMPLE_W-1:0] smallest;
        logic        [COUNT_W-1:0]  used_count;
        logic signed [SAMPLE_W-1:0] average;
        logic                       success;
    } t_result;

endpackage

FILE: design/trimmed_mean_stddev_accumulator.sv
// top level: stream ports, sample accumulator and result sequencer
//
// channel   dir  tdata bits (low first)                          tuser         tlast
// s_axis    in   sample[15:0]                                    from_target   last_attempt
// m_axis    out  average[15:0] used_count[22:16] smallest[38:23] success       -
//                largest[54:39] deviation_q8[78:55] zero[79]
//
// an attempt that is not last passes through the square and accumulate states before ready returns
// a last attempt runs 60 steps of the variance divide, 30 root steps
// and 23 steps of the mean divide, all on one compare-subtract unit
// the result sits in an output register, so the next attempt can be taken while it waits
// synchronous active-low reset clears the accumulators and the output valid
module trimmed_mean_stddev_accumulator
    import tmsa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // sample
    input  logic        s_axis_tuser,   // from_target
    input  logic        s_axis_tlast,   // last_attempt
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // average, used_count, smallest, largest, deviation_q8
    output logic        m_axis_tuser    // success
);

    t_acc_ctl  acc_ctl;
    t_acc_vals acc_vals;
    t_result   res;

    tmsa_acc u_acc (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (acc_ctl),
        .i_sample (s_axis_tdata),
        .i_tgt    (s_axis_tuser),
        .o_acc    (acc_vals)
    );

    tmsa_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .i_last      (s_axis_tlast),
        .o_ready     (s_axis_tready),
        .i_acc       (acc_vals),
        .o_ctl       (acc_ctl),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_res       (res)
    );

    assign m_axis_tdata = {1'b0, res.deviation_q8, res.largest, res.smallest,
                           res.used_count, res.average};
    assign m_axis_tuser = res.success;

endmodule

FILE: design/tmsa_cmpsub.sv
// shared compare-and-subtract step used by both dividers and the square root
module tmsa_cmpsub
    import tmsa_pkg::*;
(
    input  logic [UNIT_W-1:0] i_a,
    input  logic [UNIT_W-1:0] i_b,
    output t_unit_out         o_out
);

    logic [UNIT_W:0] diff;

    assign diff      = {1'b0, i_a} - {1'b0, i_b};
    assign o_out.ge  = ~diff[UNIT_W];
    assign o_out.res = diff[UNIT_W] ? i_a : diff[UNIT_W-1:0];

endmodule

FILE: design/tmsa_acc.sv
// running count, sum, sum of squares, minimum and maximum of accepted samples
module tmsa_acc
    import tmsa_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_acc_ctl                   i_ctl,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic                       i_tgt,
    output t_acc_vals                  o_acc
);

    logic signed [SAMPLE_W-1:0] r_sample;
    logic                       r_tgt;
    logic        [SQ_W-1:0]     r_square;
    logic        [COUNT_W-1:0]  r_count;
    logic signed [SUM_W-1:0]    r_sum;
    logic        [SQSUM_W-1:0]  r_sqsum;
    logic signed [SAMPLE_W-1:0] r_min;
    logic signed [SAMPLE_W-1:0] r_max;

    logic take;

    assign take = r_tgt && (r_count < COUNT_W'(MAX_SAMPLES));

    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_sample <= i_sample;
            r_tgt    <= i_tgt;
        end
        if (i_ctl.square) begin
            r_square <= $unsigned(SQ_W'(r_sample) * SQ_W'(r_sample));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_count <= '0;
            r_sum   <= '0;
            r_sqsum <= '0;
            r_min   <= MIN_RESET;
            r_max   <= MAX_RESET;
        end else if (i_ctl.add && take) begin
            // first sample sets both extremes
            if (r_count == '0) begin
                r_min <= r_sample;
                r_max <= r_sample;
            end else begin
                if (r_sample > r_max) r_max <= r_sample;
                if (r_sample < r_min) r_min <= r_sample;
            end
            r_count <= r_count + COUNT_W'(1);
            r_sum   <= r_sum + SUM_W'(r_sample);
            r_sqsum <= r_sqsum + SQSUM_W'(r_square);
        end
    end

    assign o_acc.count   = r_count;
    assign o_acc.sum     = r_sum;
    assign o_acc.sqsum   = r_sqsum;
    assign o_acc.min_val = r_min;
    assign o_acc.max_val = r_max;

endmodule

FILE: design/tmsa_core.sv
// sequencer: trims, forms variance terms, divides and takes the root on one shared unit
module tmsa_core
    import tmsa_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  logic      i_last,
    output logic      o_ready,
    input  t_acc_vals i_acc,
    output t_acc_ctl  o_ctl,
    input  logic      i_out_ready,
    output logic      o_out_valid,
    output t_result   o_res
);

    t_state r_state;
    t_state n_state;

    logic                       r_last;
    logic [STEP_W-1:0]          r_step;
    logic                       r_ok;
    logic                       r_trim;
    logic [COUNT_W-1:0]         r_n;
    logic signed [SUM_W-1:0]    r_sum;
    logic [SQSUM_W-1:0]         r_sq;
    logic signed [SAMPLE_W-1:0] r_min;
    logic signed [SAMPLE_W-1:0] r_max;
    logic [PROD_W-1:0]          r_prod_a;
    logic [PROD_W-1:0]          r_prod_b;
    logic [NN_W-1:0]            r_nn;
    logic [ASUM_W-1:0]          r_asum;
    logic                       r_neg;
    logic [MAG_W-1:0]           r_mag;
    logic [SHREG_W-1:0]         r_shreg;
    logic [UNIT_W-1:0]          r_rem;
    logic [ROOT_W-1:0]          r_root;
    logic                       r_out_valid;
    t_result                    r_res;

    logic [UNIT_W-1:0] unit_a;
    logic [UNIT_W-1:0] unit_b;
    t_unit_out         unit_out;
    logic              out_load;
    logic              step_end;

    logic signed [SQ_W-1:0]  sq_ext;
    logic signed [NUM_W-1:0] num;
    logic [MAG_W:0]          avg_mag;
    logic [MAG_W:0]          avg_full;
    t_result                 res_next;

    tmsa_cmpsub u_cmpsub (
        .i_a   (unit_a),
        .i_b   (unit_b),
        .o_out (unit_out)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:     if (i_valid) n_state = S_SQUARE;
            S_SQUARE:   n_state = S_ACCUM;
            S_ACCUM:    n_state = r_last ? S_TRIM : S_IDLE;
            S_TRIM:     n_state = S_TRIM_MIN;
            S_TRIM_MIN: n_state = S_MUL_A;
            S_MUL_A:    n_state = S_MUL_B;
            S_MUL_B:    n_state = S_DIFF;
            S_DIFF:     n_state = S_DEV_DIV;
            S_DEV_DIV:  if (step_end) n_state = S_SQRT;
            S_SQRT:     if (step_end) n_state = S_AVG_DIV;
            S_AVG_DIV:  if (step_end) n_state = S_DONE;
            S_DONE:     if (out_load) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // outputs and shared unit operands
    always_comb begin
        o_ready  = 1'b0;
        o_ctl    = '0;
        unit_a   = '0;
        unit_b   = '0;
        out_load = 1'b0;
        step_end = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready       = 1'b1;
                o_ctl.capture = i_valid;
            end
            S_SQUARE: o_ctl.square = 1'b1;
            S_ACCUM:  o_ctl.add = 1'b1;
            S_TRIM:   o_ctl.clear = 1'b1;
            S_DEV_DIV: begin
                unit_a   = {r_rem[UNIT_W-2:0], r_shreg[SHREG_W-1]};
                unit_b   = UNIT_W'(r_nn);
                step_end = (r_step == STEP_W'(DEV_STEPS - 1));
            end
            S_SQRT: begin
                unit_a   = {r_rem[UNIT_W-3:0], r_shreg[SHREG_W-1 -: 2]};
                unit_b   = {2'b00, r_root, 2'b01};
                step_end = (r_step == STEP_W'(SQRT_STEPS - 1));
            end
            S_AVG_DIV: begin
                unit_a   = {r_rem[UNIT_W-2:0], r_shreg[SHREG_W-1]};
                unit_b   = UNIT_W'({r_n, 1'b0});
                step_end = (r_step == STEP_W'(AVG_STEPS - 1));
            end
            S_DONE: out_load = !r_out_valid || i_out_ready;
            default: ;
        endcase
    end

    assign sq_ext = (r_state == S_TRIM) ? (i_acc.max_val * i_acc.max_val) : (r_min * r_min);
    assign num    = {r_sum[SUM_W-1], r_sum, 1'b0} + NUM_W'(r_n);

    // rounded mean is floor of num / 2n, so a negative quotient with remainder steps down
    assign avg_mag  = {1'b0, r_shreg[MAG_W-1:0]} + (MAG_W+1)'(r_rem != '0);
    assign avg_full = r_neg ? -avg_mag : {1'b0, r_shreg[MAG_W-1:0]};

    always_comb begin
        res_next.success      = r_ok;
        res_next.average      = r_ok ? avg_full[SAMPLE_W-1:0] : '0;
        res_next.used_count   = r_n;
        res_next.smallest     = r_min;
        res_next.largest      = r_max;
        res_next.deviation_q8 = (r_n > COUNT_W'(1)) ? r_root[DEV_W-1:0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == S_DEV_DIV || r_state == S_SQRT || r_state == S_AVG_DIV) && !step_end)
            begin
                r_step <= r_step + STEP_W'(1);
            end else begin
                r_step <= '0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) r_res <= res_next;
        case (r_state)
            S_IDLE: begin
                if (i_valid) r_last <= i_last;
            end
            S_TRIM: begin
                r_ok   <= (i_acc.count != '0);
                r_trim <= (i_acc.count > COUNT_W'(3));
                r_min  <= i_acc.min_val;
                r_max  <= i_acc.max_val;
                if (i_acc.count > COUNT_W'(3)) begin
                    r_n   <= i_acc.count - COUNT_W'(2);
                    r_sum <= i_acc.sum - SUM_W'(i_acc.max_val) - SUM_W'(i_acc.min_val);
                    r_sq  <= i_acc.sqsum - SQSUM_W'($unsigned(sq_ext));
                end else begin
                    r_n   <= i_acc.count;
                    r_sum <= i_acc.sum;
                    r_sq  <= i_acc.sqsum;
                end
            end
            S_TRIM_MIN: begin
                if (r_trim) r_sq <= r_sq - SQSUM_W'($unsigned(sq_ext));
            end
            S_MUL_A: begin
                r_prod_a <= PROD_W'(r_n * r_sq);
                r_nn     <= NN_W'(r_n * (r_n - COUNT_W'(1)));
                r_asum   <= r_sum[SUM_W-1] ? ASUM_W'(-r_sum) : ASUM_W'(r_sum);
                r_neg    <= num[NUM_W-1];
                r_mag    <= num[NUM_W-1] ? MAG_W'(-num) : MAG_W'(num);
            end
            S_MUL_B: begin
                r_prod_b <= PROD_W'(r_asum * r_asum);
            end
            S_DIFF: begin
                // dividend is the clipped difference scaled by 2^16
                r_shreg <= (r_prod_a > r_prod_b) ?
                           {1'b0, r_prod_a - r_prod_b, FRAC_W'(0)} : '0;
                r_rem   <= '0;
            end
            S_DEV_DIV: begin
                r_shreg <= {r_shreg[SHREG_W-2:0], unit_out.ge};
                if (step_end) begin
                    r_rem  <= '0;
                    r_root <= '0;
                end else begin
                    r_rem  <= unit_out.res;
                end
            end
            S_SQRT: begin
                r_root <= {r_root[ROOT_W-2:0], unit_out.ge};
                if (step_end) begin
                    r_rem   <= '0;
                    r_shreg <= {r_mag, (SHREG_W-MAG_W)'(0)};
                end else begin
                    r_rem   <= unit_out.res;
                    r_shreg <= {r_shreg[SHREG_W-3:0], 2'b00};
                end
            end
            S_AVG_DIV: begin
                r_rem   <= unit_out.res;
                r_shreg <= {r_shreg[SHREG_W-2:0], unit_out.ge};
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_res       = r_res;

endmodule
